### src/vna_pkg.sv
// Shared types and constants for the vertex normal accumulator.
`default_nettype none
package vna_pkg;
  localparam int MAX_VERTICES = 1024;
  localparam int VIDX_W = $clog2(MAX_VERTICES);
  localparam int VCNT_W = VIDX_W + 1;
  localparam int COORD_W = 16;
  localparam int EDGE_W = COORD_W + 1;
  localparam int SUM_W = 48;
  localparam int NORM_W = 16;
  localparam int VTX_W = 3 * COORD_W;
  localparam int SUMS_W = 3 * SUM_W;
  localparam int MUL_W = 32;
  localparam int PROD_W = 2 * MUL_W;
  localparam int MAG_W = 30;
  localparam int HI_BIT = 30;
  localparam int LO_BIT = 29;
  localparam int SQ_W = 64;
  localparam int LEN_W = 32;
  localparam int UNIT_SHIFT = 14;
  localparam int NUM_W = MAG_W + UNIT_SHIFT + 1;
  localparam int QBITS = UNIT_SHIFT + 1;
  localparam int STEP_W = 4;
  localparam int IN_DATA_W = 88;
  localparam int OUT_DATA_W = 3 * NORM_W;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = VCNT_W;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHTED = 1'd1;
  localparam logic [VCNT_W-1:0] VCOUNT_RESET = VCNT_W'(MAX_VERTICES);

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                       cmd;
    logic                       flag;
    logic [VIDX_W-1:0]          vi;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  z;
    logic [VIDX_W-1:0]          ca;
    logic [VIDX_W-1:0]          cb;
    logic [VIDX_W-1:0]          cc;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

  typedef struct packed {
    logic pop;
    logic init_busy;
  } bstat_t;

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE, ST_VWR, ST_LDA, ST_LDB, ST_LDC, ST_EDGE, ST_CROSS,
    ST_SRD, ST_SCAP, ST_ABS, ST_SHIFT, ST_SQ, ST_SQRT, ST_DSET, ST_DIV,
    ST_UDONE, ST_ACC_RD, ST_ACC_WR, ST_CLR, ST_RESP
  } bstate_t;
endpackage
`default_nettype wire

### src/vna_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module vna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

### src/vna_front.sv
// Input side: config registers, item unpacking and index range check.
`default_nettype none
module vna_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [vna_pkg::IN_DATA_W-1:0]     in_tdata,
  input  wire logic [1:0]                        in_tuser,
  input  wire logic                              cfg_we,
  input  wire logic [vna_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [vna_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                              q_full,
  input  wire vna_pkg::bstat_t                   bstat,
  output logic                                   push,
  output vna_pkg::item_t                         push_item,
  output logic                                   weighted
);
  import vna_pkg::*;

  logic [VCNT_W-1:0] vcount_r;
  logic              weighted_r;
  item_t             it;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r   <= VCOUNT_RESET;
      weighted_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VERTEX_COUNT: vcount_r <= cfg_wdata[VCNT_W-1:0];
        REG_WEIGHTED:     weighted_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // index >= count is the same as index >= min(count, MAX_VERTICES)
  always_comb begin
    it.cmd = cmd_t'(in_tuser);
    it.vi  = in_tdata[9:0];
    it.x   = in_tdata[25:10];
    it.y   = in_tdata[41:26];
    it.z   = in_tdata[57:42];
    it.ca  = in_tdata[67:58];
    it.cb  = in_tdata[77:68];
    it.cc  = in_tdata[87:78];
    case (it.cmd)
      CMD_WRITE, CMD_READ: it.flag = {1'b0, it.vi} >= vcount_r;
      CMD_ADD: it.flag = ({1'b0, it.ca} >= vcount_r) || ({1'b0, it.cb} >= vcount_r)
                         || ({1'b0, it.cc} >= vcount_r);
      default: it.flag = 1'b0;
    endcase
  end

  assign in_tready = !q_full && !bstat.init_busy;
  assign push      = in_tvalid && in_tready;
  assign push_item = it;
  assign weighted  = weighted_r;
endmodule
`default_nettype wire

### src/vna_fifo.sv
// Two-entry queue between the front and the back.
`default_nettype none
module vna_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire vna_pkg::item_t  push_item,
  input  wire logic            pop,
  output logic                 full,
  output vna_pkg::qhead_t      head
);
  import vna_pkg::*;

  item_t      mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  assign full       = cnt_r == 2'd2;
  assign head.valid = cnt_r != 2'd0;
  assign head.item  = mem_r[rp_r];
endmodule
`default_nettype wire

### src/vna_back.sv
// Execution side: vertex store, sum bank, cross product, normalization, result register.
`default_nettype none
module vna_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire vna_pkg::qhead_t                   head,
  input  wire logic                              weighted,
  output vna_pkg::bstat_t                        bstat,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [vna_pkg::OUT_DATA_W-1:0]         out_tdata,
  output logic                                   out_tuser
);
  import vna_pkg::*;

  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                       input logic signed [SUM_W-1:0] b);
    logic signed [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_add = s[SUM_W-1:0];
    end
  endfunction

  bstate_t state_r, state_nxt;
  item_t   item_r;
  logic [VIDX_W-1:0] clr_r;
  logic [STEP_W-1:0] cnt_r;
  logic [1:0]        comp_r;
  logic [1:0]        corner_r;

  logic [VTX_W-1:0]          pa_r, pb_r;
  logic signed [EDGE_W-1:0]  e1_r [3];
  logic signed [EDGE_W-1:0]  e2_r [3];
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [SUM_W-1:0]   vec_r [3];
  logic [SUM_W-1:0]          m_r [3];
  logic [2:0]                neg_r;
  logic [SQ_W-1:0]           sqv_r, root_r, bit_r;
  logic [LEN_W-1:0]          len_r;
  logic [NUM_W-1:0]          rem_r;
  logic [QBITS-1:0]          q_r;
  logic signed [NORM_W-1:0]  res_r [3];

  logic                      out_valid_r;
  logic                      out_status_r;
  logic [OUT_DATA_W-1:0]     out_data_r;

  // memories
  logic                 v_we, s_we;
  logic [VIDX_W-1:0]    v_addr, s_addr;
  logic [VTX_W-1:0]     v_wdata, v_rdata;
  logic [SUMS_W-1:0]    s_wdata, s_rdata;

  vna_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_vtx (
    .clk(clk), .we(v_we), .addr(v_addr), .wdata(v_wdata), .rdata(v_rdata)
  );

  vna_ram #(.WIDTH(SUMS_W), .DEPTH(MAX_VERTICES)) u_sum (
    .clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata)
  );

  // combinational helpers
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic [2:0]                j_idx;
  logic                      mag_big, mag_small;
  logic [SQ_W-1:0]           sq_try, root_nxt;
  logic                      sq_take;
  logic [NUM_W:0]            dvs;
  logic                      div_take;
  logic [QBITS-1:0]          q_nxt;
  logic [VIDX_W-1:0]         corner_idx;
  logic signed [SUM_W-1:0]   s_old [3];
  logic                      resp_load;

  assign j_idx = 3'(cnt_r >> 1);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == ST_SQ) begin
      mul_a = MUL_W'(m_r[comp_r][MAG_W-1:0]);
      mul_b = mul_a;
    end else begin
      case (j_idx)
        3'd0: begin mul_a = MUL_W'(e1_r[1]); mul_b = MUL_W'(e2_r[2]); end
        3'd1: begin mul_a = MUL_W'(e1_r[2]); mul_b = MUL_W'(e2_r[1]); end
        3'd2: begin mul_a = MUL_W'(e1_r[2]); mul_b = MUL_W'(e2_r[0]); end
        3'd3: begin mul_a = MUL_W'(e1_r[0]); mul_b = MUL_W'(e2_r[2]); end
        3'd4: begin mul_a = MUL_W'(e1_r[0]); mul_b = MUL_W'(e2_r[1]); end
        default: begin mul_a = MUL_W'(e1_r[1]); mul_b = MUL_W'(e2_r[0]); end
      endcase
    end
    mul_p = mul_a * mul_b;
  end

  assign mag_big   = (|m_r[0][SUM_W-1:HI_BIT]) || (|m_r[1][SUM_W-1:HI_BIT])
                     || (|m_r[2][SUM_W-1:HI_BIT]);
  assign mag_small = !((|m_r[0][SUM_W-1:LO_BIT]) || (|m_r[1][SUM_W-1:LO_BIT])
                     || (|m_r[2][SUM_W-1:LO_BIT]));

  assign sq_try   = root_r + bit_r;
  assign sq_take  = sqv_r >= sq_try;
  assign root_nxt = sq_take ? ((root_r >> 1) + bit_r) : (root_r >> 1);

  assign dvs      = (NUM_W + 1)'(len_r) << cnt_r;
  assign div_take = {1'b0, rem_r} >= dvs;
  always_comb begin
    q_nxt = q_r;
    if (div_take) begin
      q_nxt[cnt_r] = 1'b1;
    end
  end

  always_comb begin
    case (corner_r)
      2'd0:    corner_idx = item_r.ca;
      2'd1:    corner_idx = item_r.cb;
      default: corner_idx = item_r.cc;
    endcase
    s_old[0] = s_rdata[SUM_W-1:0];
    s_old[1] = s_rdata[2*SUM_W-1:SUM_W];
    s_old[2] = s_rdata[3*SUM_W-1:2*SUM_W];
  end

  assign resp_load = (state_r == ST_RESP) && (!out_valid_r || out_tready);

  // next state and memory controls
  always_comb begin
    state_nxt = state_r;
    v_we      = 1'b0;
    v_addr    = item_r.cc;
    v_wdata   = {item_r.z, item_r.y, item_r.x};
    s_we      = 1'b0;
    s_addr    = corner_idx;
    s_wdata   = {sat_add(s_old[2], vec_r[2]), sat_add(s_old[1], vec_r[1]),
                 sat_add(s_old[0], vec_r[0])};
    case (state_r)
      ST_INIT, ST_CLR: begin
        s_we    = 1'b1;
        s_addr  = clr_r;
        s_wdata = '0;
        if (clr_r == VIDX_W'(MAX_VERTICES - 1)) begin
          state_nxt = (state_r == ST_INIT) ? ST_IDLE : ST_RESP;
        end
      end
      ST_IDLE: begin
        if (head.valid) begin
          if (head.item.flag) begin
            state_nxt = ST_RESP;
          end else begin
            case (head.item.cmd)
              CMD_WRITE: state_nxt = ST_VWR;
              CMD_ADD:   state_nxt = ST_LDA;
              CMD_READ:  state_nxt = ST_SRD;
              default:   state_nxt = ST_CLR;
            endcase
          end
        end
      end
      ST_VWR: begin
        v_we      = 1'b1;
        v_addr    = item_r.vi;
        state_nxt = ST_RESP;
      end
      ST_LDA: begin
        v_addr    = item_r.ca;
        state_nxt = ST_LDB;
      end
      ST_LDB: begin
        v_addr    = item_r.cb;
        state_nxt = ST_LDC;
      end
      ST_LDC:   state_nxt = ST_EDGE;
      ST_EDGE:  state_nxt = ST_CROSS;
      ST_CROSS: begin
        if (cnt_r == STEP_W'(11)) begin
          state_nxt = weighted ? ST_ACC_RD : ST_ABS;
        end
      end
      ST_SRD: begin
        s_addr    = item_r.vi;
        state_nxt = ST_SCAP;
      end
      ST_SCAP: state_nxt = ST_ABS;
      ST_ABS: begin
        if ((vec_r[0] == '0) && (vec_r[1] == '0) && (vec_r[2] == '0)) begin
          state_nxt = ST_UDONE;
        end else begin
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (!mag_big && !mag_small) begin
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        if (cnt_r == STEP_W'(3)) begin
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (bit_r == SQ_W'(1)) begin
          state_nxt = ST_DSET;
        end
      end
      ST_DSET: state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = (comp_r == 2'd2) ? ST_UDONE : ST_DSET;
        end
      end
      ST_UDONE: state_nxt = (item_r.cmd == CMD_ADD) ? ST_ACC_RD : ST_RESP;
      ST_ACC_RD: state_nxt = ST_ACC_WR;
      ST_ACC_WR: begin
        s_we      = 1'b1;
        state_nxt = (corner_r == 2'd2) ? ST_RESP : ST_ACC_RD;
      end
      ST_RESP: begin
        if (resp_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_INIT || state_r == ST_CLR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (resp_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        item_r   <= head.item;
        corner_r <= 2'd0;
      end
      ST_LDB: pa_r <= v_rdata;
      ST_LDC: pb_r <= v_rdata;
      ST_EDGE: begin
        for (int i = 0; i < 3; i++) begin
          e1_r[i] <= EDGE_W'($signed(pa_r[i*COORD_W +: COORD_W]))
                   - EDGE_W'($signed(v_rdata[i*COORD_W +: COORD_W]));
          e2_r[i] <= EDGE_W'($signed(pb_r[i*COORD_W +: COORD_W]))
                   - EDGE_W'($signed(v_rdata[i*COORD_W +: COORD_W]));
        end
        cnt_r <= '0;
      end
      ST_CROSS: begin
        cnt_r <= cnt_r + 1'b1;
        if (!cnt_r[0]) begin
          prod_r <= mul_p;
        end else if (!j_idx[0]) begin
          vec_r[j_idx[2:1]] <= prod_r[SUM_W-1:0];
        end else begin
          vec_r[j_idx[2:1]] <= vec_r[j_idx[2:1]] - prod_r[SUM_W-1:0];
        end
      end
      ST_SCAP: begin
        vec_r[0] <= s_old[0];
        vec_r[1] <= s_old[1];
        vec_r[2] <= s_old[2];
      end
      ST_ABS: begin
        for (int i = 0; i < 3; i++) begin
          neg_r[i] <= vec_r[i][SUM_W-1];
          m_r[i]   <= vec_r[i][SUM_W-1] ? (SUM_W'(0) - vec_r[i]) : vec_r[i];
          res_r[i] <= '0;
        end
      end
      ST_SHIFT: begin
        // scale so the largest magnitude lands in [2^29, 2^30)
        for (int i = 0; i < 3; i++) begin
          if (mag_big) begin
            m_r[i] <= m_r[i] >> 1;
          end else if (mag_small) begin
            m_r[i] <= m_r[i] << 1;
          end
        end
        cnt_r  <= '0;
        comp_r <= 2'd0;
        sqv_r  <= '0;
      end
      ST_SQ: begin
        cnt_r  <= cnt_r + 1'b1;
        comp_r <= comp_r + 1'b1;
        prod_r <= mul_p;
        if (cnt_r != '0) begin
          sqv_r <= sqv_r + SQ_W'(prod_r);
        end
        root_r <= '0;
        bit_r  <= SQ_W'(1) << (SQ_W - 2);
      end
      ST_SQRT: begin
        if (sq_take) begin
          sqv_r <= sqv_r - sq_try;
        end
        root_r <= root_nxt;
        bit_r  <= bit_r >> 2;
        len_r  <= root_nxt[LEN_W-1:0];
        comp_r <= 2'd0;
      end
      ST_DSET: begin
        rem_r <= (NUM_W'(m_r[comp_r][MAG_W-1:0]) << UNIT_SHIFT) + NUM_W'(len_r >> 1);
        q_r   <= '0;
        cnt_r <= STEP_W'(UNIT_SHIFT);
      end
      ST_DIV: begin
        if (div_take) begin
          rem_r <= NUM_W'({1'b0, rem_r} - dvs);
        end
        q_r   <= q_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          res_r[comp_r] <= neg_r[comp_r] ? (NORM_W'(0) - NORM_W'(q_nxt)) : NORM_W'(q_nxt);
          comp_r        <= comp_r + 1'b1;
        end
      end
      ST_UDONE: begin
        for (int i = 0; i < 3; i++) begin
          vec_r[i] <= SUM_W'(res_r[i]);
        end
      end
      ST_ACC_WR: corner_r <= corner_r + 1'b1;
      default: ;
    endcase
    if (resp_load) begin
      out_status_r <= item_r.flag;
      if ((item_r.cmd == CMD_READ) && !item_r.flag) begin
        out_data_r <= {res_r[2], res_r[1], res_r[0]};
      end else begin
        out_data_r <= '0;
      end
    end
  end

  assign bstat.pop       = (state_r == ST_IDLE) && head.valid;
  assign bstat.init_busy = state_r == ST_INIT;
  assign out_tvalid      = out_valid_r;
  assign out_tdata       = out_data_r;
  assign out_tuser       = out_status_r;
endmodule
`default_nettype wire

### src/vertex_normal_accumulator_top.sv
// Top level of the vertex normal accumulator.
//
//  port group  dir  width       contents
//  in_*        in   88 + 2      tdata: vertex_index,x,y,z,corner_a,b,c; tuser: cmd
//  out_*       out  48 + 1      tdata: normal_x,y,z; tuser: status
//  cfg_*       in   1 + 11      index 0 vertex_count, 1 weighted
//
// Unit-weighted add and read run the normalizer: scaling shifts, squaring, root steps
// and a divide per component, all on one shared 32x32 multiplier and serial units.
// After reset a pass over every entry zeroes the sum bank; in_tready stays low meanwhile.
// A 2-entry queue and the result register keep input and output stalls apart.
`default_nettype none
module vertex_normal_accumulator_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // vertex_index[9:0], x[25:10], y[41:26], z[57:42], corner_a[67:58],
  // corner_b[77:68], corner_c[87:78]
  input  wire logic [vna_pkg::IN_DATA_W-1:0]    in_tdata,
  // cmd[1:0]
  input  wire logic [1:0]                       in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // normal_x[15:0], normal_y[31:16], normal_z[47:32]
  output logic [vna_pkg::OUT_DATA_W-1:0]        out_tdata,
  // status[0]
  output logic                                  out_tuser,
  input  wire logic                             cfg_we,
  input  wire logic [vna_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [vna_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import vna_pkg::*;

  logic   q_full;
  logic   push;
  item_t  push_item;
  qhead_t head;
  bstat_t bstat;
  logic   weighted;

  vna_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .q_full(q_full), .bstat(bstat), .push(push), .push_item(push_item), .weighted(weighted)
  );

  vna_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .push_item(push_item),
    .pop(bstat.pop), .full(q_full), .head(head)
  );

  vna_back u_back (
    .clk(clk), .rst_n(rst_n), .head(head), .weighted(weighted), .bstat(bstat),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

`ifndef SYNTHESIS
  a_init_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.init_busy |-> !in_tready)
    else $error("input accepted during sum clearing");

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("flagged result carries a normal");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[15:0]) <= 16384 && $signed(out_tdata[15:0]) >= -16384
                 && $signed(out_tdata[31:16]) <= 16384 && $signed(out_tdata[31:16]) >= -16384
                 && $signed(out_tdata[47:32]) <= 16384 && $signed(out_tdata[47:32]) >= -16384))
    else $error("normal component out of unit range");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.pop |-> head.valid)
    else $error("queue popped while empty");
`endif
endmodule
`default_nettype wire
